[hdl/complex_arith_unit_assert.svh]
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared property forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset
`define CAU_ASSERT_NEVER(lbl, bad, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error(msg);

`endif

[hdl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Payload types, operation codes, fixed-point constants and clip helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Data format: signed Q4.12
  localparam int DW = 16;
  localparam int FB = 12;
  // Product and sum widths
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  // Divider: numerator / denominator width, quotient bits
  localparam int NW = PW;
  localparam int QW = DW + 1;
  localparam int PRE_LO = FB + 1;
  localparam int HEAD = QW - PRE_LO;
  localparam int DIV_STEPS = QW;
  // Square root
  localparam int SQRT_STEPS = DW;
  localparam int SRW = DW + 2;
  // CORDIC datapath, Q6.30 angles
  localparam int CW = 36;
  localparam int GUARD = 16;
  localparam int ANG_FRAC = 30;
  localparam int CORDIC_STEPS = 16;
  localparam int GAIN_W = 32;
  localparam int PRW = DW + 1 + GAIN_W;
  // Iteration stages in the body of the pipe
  localparam int BODY_STAGES = DIV_STEPS;

  localparam logic signed [CW-1:0] PI_Q = 36'sd3373259426;
  localparam logic signed [CW-1:0] NEG_PI_Q = -36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [CW-1:0] NEG_HALF_PI_Q = -36'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q = 36'sd6746518852;
  localparam logic signed [CW-1:0] NEG_TWO_PI_Q = -36'sd6746518852;
  localparam logic signed [GAIN_W-1:0] GAIN_Q = 32'sd652032874;

  // Result range
  localparam logic signed [CW-1:0] SMAX = CW'((1 << (DW - 1)) - 1);
  localparam logic signed [CW-1:0] SMIN = CW'(-(1 << (DW - 1)));
  localparam logic [CW-1:0] UMAX = CW'((1 << (DW - 1)) - 1);
  localparam logic [CW-1:0] ULIM = CW'(1 << (DW - 1));

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_DIVR  = 4'd4,
    CMD_ABS   = 4'd5,
    CMD_ARG   = 4'd6,
    CMD_CONJ  = 4'd7,
    CMD_INV   = 4'd8,
    CMD_POLAR = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [3:0]           command;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 saturated;
    logic                 div_by_zero;
  } out_t;

  typedef struct packed {
    logic                 sat;
    logic signed [DW-1:0] val;
  } clip_t;

  // State carried through the iteration stages
  typedef struct packed {
    logic [3:0]           cmd;
    // results of the single-pass operations
    logic signed [DW-1:0] q_re;
    logic signed [DW-1:0] q_im;
    logic                 q_sat;
    logic                 q_dz;
    // two restoring divider lanes on one denominator
    logic [NW-1:0]        den;
    logic [NW-1:0]        rem_re;
    logic [NW-1:0]        rem_im;
    logic [QW-1:0]        low_re;
    logic [QW-1:0]        low_im;
    logic [QW-1:0]        quo_re;
    logic [QW-1:0]        quo_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 neg_re;
    logic                 neg_im;
    // digit-by-digit square root
    logic [NW-1:0]        sq_n;
    logic [SRW-1:0]       sq_rem;
    logic [DW-1:0]        sq_root;
    // CORDIC, vectoring or rotation
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic                 vec;
    logic                 zero;
  } body_t;

  // atan(2^-i) in Q6.30
  function automatic logic signed [CW-1:0] atan_q(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = CW'(843314857);
      1:  v = CW'(497837829);
      2:  v = CW'(263043837);
      3:  v = CW'(133525159);
      4:  v = CW'(67021687);
      5:  v = CW'(33543516);
      6:  v = CW'(16775851);
      7:  v = CW'(8388437);
      8:  v = CW'(4194283);
      9:  v = CW'(2097149);
      10: v = CW'(1048576);
      11: v = CW'(524288);
      12: v = CW'(262144);
      13: v = CW'(131072);
      14: v = CW'(65536);
      15: v = CW'(32768);
      16: v = CW'(16384);
      17: v = CW'(8192);
      18: v = CW'(4096);
      19: v = CW'(2048);
      20: v = CW'(1024);
      21: v = CW'(512);
      22: v = CW'(256);
      23: v = CW'(128);
      24: v = CW'(64);
      25: v = CW'(32);
      26: v = CW'(16);
      27: v = CW'(8);
      28: v = CW'(4);
      29: v = CW'(2);
      30: v = CW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clip a signed value to the result range
  function automatic clip_t clip_s(input logic signed [CW-1:0] v);
    clip_t c;
    c.sat = 1'b0;
    c.val = v[DW-1:0];
    if (v > SMAX) begin
      c.sat = 1'b1;
      c.val = SMAX[DW-1:0];
    end else if (v < SMIN) begin
      c.sat = 1'b1;
      c.val = SMIN[DW-1:0];
    end
    return c;
  endfunction

  // Clip a sign-magnitude value to the result range
  function automatic clip_t clip_mag(input logic [CW-1:0] m, input logic neg);
    clip_t c;
    logic [CW-1:0] nm;
    nm = -m;
    c.sat = 1'b0;
    if (neg) begin
      c.val = nm[DW-1:0];
      if (m > ULIM) begin
        c.sat = 1'b1;
        c.val = SMIN[DW-1:0];
      end
    end else begin
      c.val = m[DW-1:0];
      if (m > UMAX) begin
        c.sat = 1'b1;
        c.val = SMAX[DW-1:0];
      end
    end
    return c;
  endfunction

endpackage

[hdl/cau_step.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// One registered step of the divider lanes, the square root and the CORDIC.
// ----------------------------------------------------------------------------
module cau_step #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  cau_pkg::body_t in_data,
  output logic           out_valid,
  output cau_pkg::body_t out_data
);
  import cau_pkg::*;

  localparam logic signed [CW-1:0] AT = atan_q(STEP);

  body_t             d_nxt;
  body_t             out_data_r;
  logic              out_valid_r;
  logic [NW:0]       r_re, r_im, dv_re, dv_im;
  logic              ge_re, ge_im, ge_sq, sel;
  logic [SRW+1:0]    sq_t, sq_trial, sq_diff;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    d_nxt = in_data;

    // divider: one quotient bit per lane
    r_re  = {in_data.rem_re, in_data.low_re[QW-1]};
    r_im  = {in_data.rem_im, in_data.low_im[QW-1]};
    dv_re = r_re - {1'b0, in_data.den};
    dv_im = r_im - {1'b0, in_data.den};
    ge_re = r_re >= {1'b0, in_data.den};
    ge_im = r_im >= {1'b0, in_data.den};
    if (STEP < DIV_STEPS) begin
      d_nxt.rem_re = ge_re ? dv_re[NW-1:0] : r_re[NW-1:0];
      d_nxt.rem_im = ge_im ? dv_im[NW-1:0] : r_im[NW-1:0];
      d_nxt.low_re = in_data.low_re << 1;
      d_nxt.low_im = in_data.low_im << 1;
      d_nxt.quo_re = {in_data.quo_re[QW-2:0], ge_re};
      d_nxt.quo_im = {in_data.quo_im[QW-2:0], ge_im};
    end

    // square root: one root bit from two radicand bits
    sq_t     = {in_data.sq_rem, in_data.sq_n[NW-1 -: 2]};
    sq_trial = (SRW+2)'({in_data.sq_root, 2'b01});
    sq_diff  = sq_t - sq_trial;
    ge_sq    = sq_t >= sq_trial;
    if (STEP < SQRT_STEPS) begin
      d_nxt.sq_rem  = ge_sq ? sq_diff[SRW-1:0] : sq_t[SRW-1:0];
      d_nxt.sq_root = {in_data.sq_root[DW-2:0], ge_sq};
      d_nxt.sq_n    = in_data.sq_n << 2;
    end

    // CORDIC micro-rotation
    dx  = in_data.cx >>> STEP;
    dy  = in_data.cy >>> STEP;
    sel = in_data.vec ? (in_data.cy < 0) : (in_data.cz >= 0);
    if (STEP < CORDIC_STEPS) begin
      if (sel) begin
        d_nxt.cx = in_data.cx - dy;
        d_nxt.cy = in_data.cy + dx;
        d_nxt.cz = in_data.cz - AT;
      end else begin
        d_nxt.cx = in_data.cx + dy;
        d_nxt.cy = in_data.cy - dx;
        d_nxt.cz = in_data.cz + AT;
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= d_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Ten operations on signed Q4.12 complex operands, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one item per clock when the output is not stalled and
// returns one result item per item, in order. Four front stages form
// products, sums, angle reduction and iteration seeds; seventeen iteration
// stages run the restoring divider (one quotient bit per stage), the square
// root (one root bit per stage) and a shared 16-step CORDIC; the last stage
// rounds, clips and holds the result. A stall at the output freezes the
// whole pipe, so in_ready is low only while a result waits to be taken.
module complex_arith_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cau_pkg::out_t out_data
);
  import cau_pkg::*;

  typedef struct packed {
    logic [3:0]           cmd;
    logic signed [DW-1:0] ar, ai, br, bi;
    logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
    logic signed [CW-1:0] z;
  } f1_t;

  typedef struct packed {
    logic [3:0]           cmd;
    logic signed [DW-1:0] ar, ai, br, bi;
    logic signed [SW-1:0] sa, sb;
    logic [NW-1:0]        den;
    logic signed [CW-1:0] z;
  } f2_t;

  typedef struct packed {
    logic [3:0]           cmd;
    logic signed [DW-1:0] ar, ai;
    logic signed [DW-1:0] q_re, q_im;
    logic                 q_sat, q_dz;
    logic [NW-1:0]        num_re, num_im, den;
    logic                 neg_re, neg_im;
    logic [NW-1:0]        sq_n;
    logic signed [CW-1:0] z;
    logic signed [DW:0]   r;
  } f3_t;

  logic  en;
  f1_t   f1_nxt, f1_r;
  f2_t   f2_nxt, f2_r;
  f3_t   f3_nxt, f3_r;
  body_t b0_nxt, b0_r;
  logic  f1_v_r, f2_v_r, f3_v_r, b0_v_r;
  body_t bd [0:BODY_STAGES];
  logic [BODY_STAGES:0] bv;
  body_t t;
  out_t  out_nxt, out_data_r;
  logic  out_valid_r;

  // whole pipe advances unless a result is held
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: products and first angle wrap
  logic signed [DW-1:0] u1, v1;
  logic signed [CW-1:0] z0;
  always_comb begin
    u1 = (in_data.command == CMD_DIV) ? in_data.b_re : in_data.a_re;
    v1 = (in_data.command == CMD_DIV) ? in_data.b_im : in_data.a_im;
    f1_nxt.cmd = in_data.command;
    f1_nxt.ar  = in_data.a_re;
    f1_nxt.ai  = in_data.a_im;
    f1_nxt.br  = in_data.b_re;
    f1_nxt.bi  = in_data.b_im;
    f1_nxt.p0  = PW'(in_data.a_re) * PW'(in_data.b_re);
    f1_nxt.p1  = PW'(in_data.a_im) * PW'(in_data.b_im);
    f1_nxt.p2  = PW'(in_data.a_re) * PW'(in_data.b_im);
    f1_nxt.p3  = PW'(in_data.a_im) * PW'(in_data.b_re);
    f1_nxt.p4  = PW'(u1) * PW'(u1);
    f1_nxt.p5  = PW'(v1) * PW'(v1);
    z0 = CW'(in_data.a_im) <<< (ANG_FRAC - FB);
    if (z0 >= TWO_PI_Q) begin
      f1_nxt.z = z0 - TWO_PI_Q;
    end else if (z0 <= NEG_TWO_PI_Q) begin
      f1_nxt.z = z0 + TWO_PI_Q;
    end else begin
      f1_nxt.z = z0;
    end
  end

  // stage 2: sums of products, wrap angle into [-pi, pi]
  always_comb begin
    f2_nxt.cmd = f1_r.cmd;
    f2_nxt.ar  = f1_r.ar;
    f2_nxt.ai  = f1_r.ai;
    f2_nxt.br  = f1_r.br;
    f2_nxt.bi  = f1_r.bi;
    if (f1_r.cmd == CMD_MUL) begin
      f2_nxt.sa = SW'(f1_r.p0) - SW'(f1_r.p1);
      f2_nxt.sb = SW'(f1_r.p2) + SW'(f1_r.p3);
    end else begin
      f2_nxt.sa = SW'(f1_r.p0) + SW'(f1_r.p1);
      f2_nxt.sb = SW'(f1_r.p3) - SW'(f1_r.p2);
    end
    f2_nxt.den = $unsigned(f1_r.p4) + $unsigned(f1_r.p5);
    if (f1_r.z > PI_Q) begin
      f2_nxt.z = f1_r.z - TWO_PI_Q;
    end else if (f1_r.z < NEG_PI_Q) begin
      f2_nxt.z = f1_r.z + TWO_PI_Q;
    end else begin
      f2_nxt.z = f1_r.z;
    end
  end

  // stage 3: single-pass results, divider operands, polar fold
  logic [SW-1:0]       ma, mb, rnd_a, rnd_b;
  logic signed [DW:0]  ar_x, ai_x, br_x;
  logic [DW:0]         mar, mai, mbr;
  clip_t               cr, ci;
  logic                rneg;
  always_comb begin
    ma   = f2_r.sa[SW-1] ? $unsigned(-f2_r.sa) : $unsigned(f2_r.sa);
    mb   = f2_r.sb[SW-1] ? $unsigned(-f2_r.sb) : $unsigned(f2_r.sb);
    rnd_a = (ma >> FB) + SW'(ma[FB-1]);
    rnd_b = (mb >> FB) + SW'(mb[FB-1]);
    ar_x = (DW+1)'(f2_r.ar);
    ai_x = (DW+1)'(f2_r.ai);
    br_x = (DW+1)'(f2_r.br);
    mar  = ar_x[DW] ? $unsigned(-ar_x) : $unsigned(ar_x);
    mai  = ai_x[DW] ? $unsigned(-ai_x) : $unsigned(ai_x);
    mbr  = br_x[DW] ? $unsigned(-br_x) : $unsigned(br_x);
    cr   = '0;
    ci   = '0;

    f3_nxt        = '0;
    f3_nxt.cmd    = f2_r.cmd;
    f3_nxt.ar     = f2_r.ar;
    f3_nxt.ai     = f2_r.ai;
    case (f2_r.cmd)
      CMD_ADD: begin
        cr = clip_s(CW'(f2_r.ar) + CW'(f2_r.br));
        ci = clip_s(CW'(f2_r.ai) + CW'(f2_r.bi));
      end
      CMD_SUB: begin
        cr = clip_s(CW'(f2_r.ar) - CW'(f2_r.br));
        ci = clip_s(CW'(f2_r.ai) - CW'(f2_r.bi));
      end
      CMD_MUL: begin
        cr = clip_mag(CW'(rnd_a), f2_r.sa[SW-1]);
        ci = clip_mag(CW'(rnd_b), f2_r.sb[SW-1]);
      end
      CMD_CONJ: begin
        cr = clip_s(CW'(f2_r.ar));
        ci = clip_s(-CW'(f2_r.ai));
      end
      CMD_DIV: begin
        f3_nxt.num_re = ma[NW-1:0];
        f3_nxt.num_im = mb[NW-1:0];
        f3_nxt.den    = f2_r.den;
        f3_nxt.neg_re = f2_r.sa[SW-1];
        f3_nxt.neg_im = f2_r.sb[SW-1];
        f3_nxt.q_dz   = (f2_r.den == '0);
      end
      CMD_DIVR: begin
        f3_nxt.num_re = NW'(mar);
        f3_nxt.num_im = NW'(mai);
        f3_nxt.den    = NW'(mbr);
        f3_nxt.neg_re = f2_r.ar[DW-1] ^ f2_r.br[DW-1];
        f3_nxt.neg_im = f2_r.ai[DW-1] ^ f2_r.br[DW-1];
        f3_nxt.q_dz   = (f2_r.br == '0);
      end
      CMD_INV: begin
        f3_nxt.num_re = NW'(mar) << FB;
        f3_nxt.num_im = NW'(mai) << FB;
        f3_nxt.den    = f2_r.den;
        f3_nxt.neg_re = f2_r.ar[DW-1];
        f3_nxt.neg_im = (f2_r.ai > 0);
        f3_nxt.q_dz   = (f2_r.den == '0);
      end
      CMD_ABS: begin
        f3_nxt.sq_n = f2_r.den;
      end
      default: begin
      end
    endcase
    f3_nxt.q_re  = cr.val;
    f3_nxt.q_im  = ci.val;
    f3_nxt.q_sat = cr.sat | ci.sat;

    // fold angle into [-pi/2, pi/2], negating the radius
    rneg     = 1'b0;
    f3_nxt.z = f2_r.z;
    if (f2_r.z > HALF_PI_Q) begin
      f3_nxt.z = f2_r.z - PI_Q;
      rneg     = 1'b1;
    end else if (f2_r.z < NEG_HALF_PI_Q) begin
      f3_nxt.z = f2_r.z + PI_Q;
      rneg     = 1'b1;
    end
    f3_nxt.r = rneg ? -ar_x : ar_x;
  end

  // stage 4: divider overflow test and seeds, CORDIC seeds
  logic signed [PRW-1:0] gprod;
  logic signed [CW-1:0]  xa, ya;
  always_comb begin
    gprod = PRW'(f3_r.r) * PRW'(GAIN_Q);
    xa    = CW'(f3_r.ar) <<< GUARD;
    ya    = CW'(f3_r.ai) <<< GUARD;

    b0_nxt        = '0;
    b0_nxt.cmd    = f3_r.cmd;
    b0_nxt.q_re   = f3_r.q_re;
    b0_nxt.q_im   = f3_r.q_im;
    b0_nxt.q_sat  = f3_r.q_sat;
    b0_nxt.q_dz   = f3_r.q_dz;
    b0_nxt.den    = f3_r.den;
    b0_nxt.neg_re = f3_r.neg_re;
    b0_nxt.neg_im = f3_r.neg_im;
    b0_nxt.ovf_re = {{HEAD{1'b0}}, f3_r.num_re} >= {f3_r.den, {HEAD{1'b0}}};
    b0_nxt.ovf_im = {{HEAD{1'b0}}, f3_r.num_im} >= {f3_r.den, {HEAD{1'b0}}};
    b0_nxt.rem_re = f3_r.num_re >> HEAD;
    b0_nxt.rem_im = f3_r.num_im >> HEAD;
    b0_nxt.low_re = {f3_r.num_re[HEAD-1:0], {PRE_LO{1'b0}}};
    b0_nxt.low_im = {f3_r.num_im[HEAD-1:0], {PRE_LO{1'b0}}};
    b0_nxt.sq_n   = f3_r.sq_n;

    if (f3_r.cmd == CMD_ARG) begin
      b0_nxt.vec  = 1'b1;
      b0_nxt.zero = (f3_r.ar == '0) && (f3_r.ai == '0);
      if (f3_r.ar[DW-1]) begin
        b0_nxt.cx = -xa;
        b0_nxt.cy = -ya;
        b0_nxt.cz = f3_r.ai[DW-1] ? NEG_PI_Q : PI_Q;
      end else begin
        b0_nxt.cx = xa;
        b0_nxt.cy = ya;
      end
    end else begin
      b0_nxt.cx = CW'(gprod >>> (ANG_FRAC - GUARD));
      b0_nxt.cz = f3_r.z;
    end
  end

  // front-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      b0_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      b0_v_r <= f3_v_r;
    end
  end

  // front-end payload
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
      b0_r <= b0_nxt;
    end
  end

  // iteration stages
  assign bd[0] = b0_r;
  assign bv[0] = b0_v_r;
  for (genvar k = 0; k < BODY_STAGES; k++) begin : g_step
    cau_step #(.STEP(k)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (bv[k]),
      .in_data   (bd[k]),
      .out_valid (bv[k+1]),
      .out_data  (bd[k+1])
    );
  end
  assign t = bd[BODY_STAGES];

  // finish: round and clip by operation
  logic [QW-1:0]        dq_re, dq_im;
  logic [DW:0]          sq_r;
  logic signed [CW-1:0] za, xr, yr;
  clip_t                tr, ti;
  always_comb begin
    dq_re = {1'b0, t.quo_re[QW-1:1]} + QW'(t.quo_re[0]);
    dq_im = {1'b0, t.quo_im[QW-1:1]} + QW'(t.quo_im[0]);
    sq_r  = {1'b0, t.sq_root} + (DW+1)'(t.sq_rem > SRW'(t.sq_root));
    za    = (t.cz + CW'(1 << (ANG_FRAC - FB - 1))) >>> (ANG_FRAC - FB);
    xr    = (t.cx + CW'(1 << (GUARD - 1))) >>> GUARD;
    yr    = (t.cy + CW'(1 << (GUARD - 1))) >>> GUARD;
    tr    = '0;
    ti    = '0;
    out_nxt = '0;
    case (t.cmd)
      CMD_DIV, CMD_DIVR, CMD_INV: begin
        if (!t.q_dz) begin
          tr = clip_mag(t.ovf_re ? '1 : CW'(dq_re), t.neg_re);
          ti = clip_mag(t.ovf_im ? '1 : CW'(dq_im), t.neg_im);
        end
        out_nxt.div_by_zero = t.q_dz;
      end
      CMD_ABS: begin
        tr = clip_mag(CW'(sq_r), 1'b0);
      end
      CMD_ARG: begin
        if (!t.zero) begin
          tr = clip_s(za);
        end
      end
      CMD_POLAR: begin
        tr = clip_s(xr);
        ti = clip_s(yr);
      end
      default: begin
        tr.val = t.q_re;
        ti.val = t.q_im;
        tr.sat = t.q_sat;
      end
    endcase
    out_nxt.res_re    = tr.val;
    out_nxt.res_im    = ti.val;
    out_nxt.saturated = tr.sat | ti.sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= bv[BODY_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `include "complex_arith_unit_assert.svh"

  `CAU_ASSERT_IMP(a_dz_clears, out_valid && out_data.div_by_zero, (out_data.res_re == '0) && (out_data.res_im == '0), "zero divisor result not cleared")
  `CAU_ASSERT_NEVER(a_flags_excl, out_valid && out_data.saturated && out_data.div_by_zero, "saturated and divide by zero both set")
  `CAU_ASSERT_IMP(a_div_rem, bv[BODY_STAGES] && (t.cmd == CMD_DIV || t.cmd == CMD_DIVR || t.cmd == CMD_INV) && !t.q_dz && !t.ovf_re, t.rem_re < t.den, "divider remainder not below divisor")
  `CAU_ASSERT_IMP(a_sqrt_rem, bv[BODY_STAGES] && (t.cmd == CMD_ABS), t.sq_rem <= SRW'({t.sq_root, 1'b0}), "square root remainder out of bound")
  `CAU_ASSERT_IMP(a_vec_x, bv[BODY_STAGES] && t.vec, t.cx >= 0, "vectoring x went negative")

endmodule
